// File: rtl/core/wdcm_pkg.sv
// Shared constants, types and helper functions for the work dispatcher.
`default_nettype none
package wdcm_pkg;

    localparam int MAX_TASKS   = 1024;
    localparam int MAX_WORKERS = 64;

    // Completion map is kept as rows of done bits.
    localparam int WORD_W = 32;
    localparam int ROWS   = MAX_TASKS / WORD_W;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int BIT_W  = $clog2(WORD_W);

    localparam int TASK_W   = 10;
    localparam int WORKER_W = 6;
    localparam int TCNT_W   = 11;
    localparam int WCNT_W   = 7;
    localparam int PTR_W    = TCNT_W;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_DONE    = 1'b1;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_STOP   = 1'b1;

    localparam logic [1:0] CFG_TASK_COUNT   = 2'd0;
    localparam logic [1:0] CFG_WORKER_COUNT = 2'd1;

    // Access to the completion map for one cycle.
    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic             clear;
    } map_req_t;

    // Index of the highest set bit of a row.
    function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (v[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/work_dispatcher_with_completion_map.sv
// Work dispatcher: hands out tasks from a descending pointer, skipping those marked done.
// Done report in range: busy after acceptance while the row is read, then set and written back.
// Request: the scan reads one 32-task row of the map per cycle and registers an assign result for
// the first free task found; S_STOP then adds a stop result if that was task 0 or none was free.
// Request with the pointer exhausted: stop result the next cycle, no busy time.
// Reset and a task or worker count write clear the map at once via row valid bits (no clear pass).
`default_nettype none
module work_dispatcher_with_completion_map (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              operation,
    input  wire logic [wdcm_pkg::WORKER_W-1:0]     worker_id,
    input  wire logic [wdcm_pkg::TASK_W-1:0]       task_index,
    output logic                                   result_strobe,
    output logic                                   kind,
    output logic      [wdcm_pkg::WORKER_W-1:0]     destination,
    output logic      [wdcm_pkg::TASK_W-1:0]       assigned_task,
    output logic                                   finished,
    output logic                                   last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [wdcm_pkg::TCNT_W-1:0]       cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SET  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_STOP = 2'd3;

    localparam logic [wdcm_pkg::TCNT_W-1:0] TCNT_MAX = wdcm_pkg::TCNT_W'(wdcm_pkg::MAX_TASKS);
    localparam logic [wdcm_pkg::WCNT_W-1:0] WCNT_MAX =
        wdcm_pkg::WCNT_W'(wdcm_pkg::MAX_WORKERS);

    logic [1:0]                        state_reg, state_next;
    logic [wdcm_pkg::TCNT_W-1:0]       task_count_reg, task_count_next;
    logic [wdcm_pkg::WCNT_W-1:0]       worker_count_reg, worker_count_next;
    logic [wdcm_pkg::PTR_W-1:0]        ptr_reg, ptr_next;
    logic [wdcm_pkg::WCNT_W-1:0]       active_reg, active_next;
    logic                              released_reg, released_next;
    logic [wdcm_pkg::WORKER_W-1:0]     worker_reg, worker_next;
    logic [wdcm_pkg::TASK_W-1:0]       task_reg, task_next;

    logic                              strobe_reg, strobe_next;
    logic                              kind_reg, kind_next;
    logic [wdcm_pkg::WORKER_W-1:0]     dest_reg, dest_next;
    logic [wdcm_pkg::TASK_W-1:0]       assigned_reg, assigned_next;
    logic                              fin_reg, fin_next;
    logic                              last_reg, last_next;

    wdcm_pkg::map_req_t                map_req;
    logic [wdcm_pkg::WORD_W-1:0]       map_wr_data;
    logic [wdcm_pkg::WORD_W-1:0]       rd_word;

    logic                              accept;
    logic                              cfg_write;
    logic [wdcm_pkg::TCNT_W-1:0]       tc_sat;
    logic [wdcm_pkg::WCNT_W-1:0]       wc_sat;

    logic [wdcm_pkg::ROW_W-1:0]        ptr_row;
    logic [wdcm_pkg::BIT_W-1:0]        ptr_bit;
    logic [wdcm_pkg::WORD_W-1:0]       free_bits;
    logic [wdcm_pkg::BIT_W-1:0]        hit_bit;
    logic [wdcm_pkg::TASK_W-1:0]       hit_task;
    logic [wdcm_pkg::WCNT_W-1:0]       active_dec;

    wdcm_map u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (map_req),
        .wr_data(map_wr_data),
        .rd_word(rd_word)
    );

    assign busy      = (state_reg != S_IDLE);
    // Hold off a register write while a transaction is being offered.
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    assign ptr_row = ptr_reg[wdcm_pkg::TASK_W-1:wdcm_pkg::BIT_W];
    assign ptr_bit = ptr_reg[wdcm_pkg::BIT_W-1:0];

    // Unfinished tasks in the current row at or below the pointer.
    assign free_bits = ~rd_word
        & ({wdcm_pkg::WORD_W{1'b1}} >> (wdcm_pkg::BIT_W'(wdcm_pkg::WORD_W - 1) - ptr_bit));
    assign hit_bit   = wdcm_pkg::top_bit(free_bits);
    assign hit_task  = {ptr_row, hit_bit};

    assign active_dec = (active_reg != '0) ? active_reg - 1'b1 : active_reg;

    always_comb
    begin
        tc_sat = cfg_data;
        if (tc_sat == '0)
        begin
            tc_sat = wdcm_pkg::TCNT_W'(1);
        end
        else if (tc_sat > TCNT_MAX)
        begin
            tc_sat = TCNT_MAX;
        end
        wc_sat = cfg_data[wdcm_pkg::WCNT_W-1:0];
        if (wc_sat == '0)
        begin
            wc_sat = wdcm_pkg::WCNT_W'(1);
        end
        else if (wc_sat > WCNT_MAX)
        begin
            wc_sat = WCNT_MAX;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        task_count_next   = task_count_reg;
        worker_count_next = worker_count_reg;
        ptr_next          = ptr_reg;
        active_next       = active_reg;
        released_next     = released_reg;
        worker_next       = worker_reg;
        task_next         = task_reg;

        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        dest_next     = dest_reg;
        assigned_next = assigned_reg;
        fin_next      = fin_reg;
        last_next     = last_reg;

        map_req     = '0;
        map_wr_data = rd_word | (wdcm_pkg::WORD_W'(1) << task_reg[wdcm_pkg::BIT_W-1:0]);

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_write && (cfg_index == wdcm_pkg::CFG_TASK_COUNT
                                  || cfg_index == wdcm_pkg::CFG_WORKER_COUNT))
                begin
                    // New run: clear the map and reload the counters.
                    if (cfg_index == wdcm_pkg::CFG_TASK_COUNT)
                    begin
                        task_count_next = tc_sat;
                        ptr_next        = tc_sat - 1'b1;
                        active_next     = worker_count_reg;
                    end
                    else
                    begin
                        worker_count_next = wc_sat;
                        ptr_next          = task_count_reg - 1'b1;
                        active_next       = wc_sat;
                    end
                    released_next = 1'b0;
                    map_req.clear = 1'b1;
                end
                else if (accept && !released_reg)
                begin
                    worker_next = worker_id;
                    task_next   = task_index;
                    if (operation == wdcm_pkg::OP_DONE)
                    begin
                        if ({1'b0, task_index} < task_count_reg)
                        begin
                            map_req.rd_en  = 1'b1;
                            map_req.rd_row = task_index[wdcm_pkg::TASK_W-1:wdcm_pkg::BIT_W];
                            state_next     = S_SET;
                        end
                    end
                    else if (ptr_reg[wdcm_pkg::PTR_W-1])
                    begin
                        // Pointer exhausted: stop only.
                        strobe_next   = 1'b1;
                        kind_next     = wdcm_pkg::KIND_STOP;
                        dest_next     = worker_id;
                        assigned_next = '0;
                        fin_next      = (active_dec == '0);
                        last_next     = 1'b1;
                        active_next   = active_dec;
                        released_next = (active_dec == '0);
                    end
                    else
                    begin
                        map_req.rd_en  = 1'b1;
                        map_req.rd_row = ptr_row;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_SET:
            begin
                map_req.wr_en  = 1'b1;
                map_req.wr_row = task_reg[wdcm_pkg::TASK_W-1:wdcm_pkg::BIT_W];
                state_next     = S_IDLE;
            end

            S_SCAN:
            begin
                if (free_bits != '0)
                begin
                    strobe_next   = 1'b1;
                    kind_next     = wdcm_pkg::KIND_ASSIGN;
                    dest_next     = worker_reg;
                    assigned_next = hit_task;
                    fin_next      = 1'b0;
                    ptr_next      = {1'b0, hit_task} - 1'b1;
                    if (hit_task == '0)
                    begin
                        last_next  = 1'b0;
                        state_next = S_STOP;
                    end
                    else
                    begin
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // Row fully done: step to the top of the row below.
                    ptr_next = {1'b0, ptr_row, {wdcm_pkg::BIT_W{1'b0}}} - 1'b1;
                    if (ptr_row == '0)
                    begin
                        state_next = S_STOP;
                    end
                    else
                    begin
                        map_req.rd_en  = 1'b1;
                        map_req.rd_row = ptr_row - 1'b1;
                    end
                end
            end

            S_STOP:
            begin
                strobe_next   = 1'b1;
                kind_next     = wdcm_pkg::KIND_STOP;
                dest_next     = worker_reg;
                assigned_next = '0;
                fin_next      = (active_dec == '0);
                last_next     = 1'b1;
                active_next   = active_dec;
                released_next = (active_dec == '0);
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            task_count_reg   <= TCNT_MAX;
            worker_count_reg <= wdcm_pkg::WCNT_W'(1);
            ptr_reg          <= TCNT_MAX - 1'b1;
            active_reg       <= wdcm_pkg::WCNT_W'(1);
            released_reg     <= 1'b0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            task_count_reg   <= task_count_next;
            worker_count_reg <= worker_count_next;
            ptr_reg          <= ptr_next;
            active_reg       <= active_next;
            released_reg     <= released_next;
            strobe_reg       <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        worker_reg   <= worker_next;
        task_reg     <= task_next;
        kind_reg     <= kind_next;
        dest_reg     <= dest_next;
        assigned_reg <= assigned_next;
        fin_reg      <= fin_next;
        last_reg     <= last_next;
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign destination   = dest_reg;
    assign assigned_task = assigned_reg;
    assign finished      = fin_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

// File: rtl/core/wdcm_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module wdcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/core/wdcm_map.sv
// Completion map: RAM of done rows with a per-row valid bit for instant clear.
`default_nettype none
module wdcm_map (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire wdcm_pkg::map_req_t              req,
    input  wire logic [wdcm_pkg::WORD_W-1:0]     wr_data,
    output logic      [wdcm_pkg::WORD_W-1:0]     rd_word
);

    logic [wdcm_pkg::ROWS-1:0]   row_valid_reg;
    logic                        rd_valid_reg;
    logic [wdcm_pkg::WORD_W-1:0] ram_rd_data;

    wdcm_ram #(
        .WIDTH(wdcm_pkg::WORD_W),
        .DEPTH(wdcm_pkg::ROWS)
    ) u_ram (
        .clk    (clk),
        .rd_en  (req.rd_en),
        .rd_addr(req.rd_row),
        .rd_data(ram_rd_data),
        .wr_en  (req.wr_en),
        .wr_addr(req.wr_row),
        .wr_data(wr_data)
    );

    // A row never written since the last clear reads as all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                row_valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                row_valid_reg[req.wr_row] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[req.rd_row];
            end
        end
    end

    assign rd_word = rd_valid_reg ? ram_rd_data : '0;

endmodule
`default_nettype wire
